// ----- design/ekvrc_pkg.sv -----
// Shared types and constants for the expiring key-value ring cache.
`timescale 1ns / 1ps
package ekvrc_pkg;

   localparam int KEY_DEPTH = 1024;

   // Command codes carried in req_tuser.
   localparam logic [1:0] OP_SET  = 2'd0;
   localparam logic [1:0] OP_GET  = 2'd1;
   localparam logic [1:0] OP_DEL  = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   // Result codes carried in rsp_tuser.
   localparam logic [2:0] ST_DONE  = 3'd0;
   localparam logic [2:0] ST_FOUND = 3'd1;
   localparam logic [2:0] ST_MISS  = 3'd2;
   localparam logic [2:0] ST_IGN   = 3'd3;
   localparam logic [2:0] ST_FAULT = 3'd4;

   localparam logic [31:0] HASH_SEED = 32'd5381;
   localparam logic [19:0] TTL_CAP   = 20'd604800;
   localparam logic [4:0]  HDR_BYTES = 5'd20;
   localparam logic [3:0]  DEL_BACK  = 4'd10;
   localparam logic [63:0] TIME_OFS  = 64'h4000_0000_0000_0000;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic [61:0] now_seconds;
      logic [31:0] ttl_seconds;
      logic [15:0] data_len;
      logic [9:0]  key_len;
   } req_data_type;

   typedef struct packed {
      logic [3:0]  pad;
      logic [19:0] ttl_left;
      logic [15:0] found_len;
      logic [15:0] data_offset;
   } rsp_data_type;

endpackage

// ----- design/expiring_kv_ring_cache.sv -----
// Top level of the expiring key-value ring cache: arena, sequencer and stream ports.
`timescale 1ns / 1ps
// Key-value cache in a byte arena, driven by set/get/delete commands that arrive one byte
// per beat. After reset a clearing pass zeroes the arena while req_tready stays low. Each key
// or data beat passes through the start and byte states before req_tready rises again. The
// first beat of a set also evicts old entries from the oldest end until the new entry fits.
// The last beat of a command runs a sequencer over the arena, one byte per cycle: a set links
// its entry at the head of its bucket chain; a get or delete walks the chain, comparing each
// entry's key length and key bytes, then on a hit reads its expiry. One result beat follows
// each last beat and may wait in the output register while the next command streams in.
module expiring_kv_ring_cache #(
   parameter int ARENA_BYTES = 65536,
   parameter int HEAD_BYTES  = 4096,
   parameter int MAX_KEY     = 1000,
   parameter int MAX_DATA    = 16384,
   parameter int CHAIN_LIMIT = 100
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // key_len, data_len, ttl_seconds, now_seconds, byte_value
   input  ekvrc_pkg::req_data_type  req_tdata,
   // op
   input  logic [1:0]               req_tuser,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // data_offset, found_len, ttl_left, zero pad
   output ekvrc_pkg::rsp_data_type  rsp_tdata,
   // status
   output logic [2:0]               rsp_tuser
);
   import ekvrc_pkg::*;

   localparam int AW = $clog2(ARENA_BYTES);
   localparam int PW = AW + 1;
   localparam int LW = $clog2(CHAIN_LIMIT + 2);
   localparam logic [31:0] ARENA32 = 32'(ARENA_BYTES);
   localparam logic [31:0] HEAD32  = 32'(HEAD_BYTES);
   localparam logic [31:0] HMASK   = 32'(HEAD_BYTES - 4);

   typedef enum logic [5:0] {
      S_CLEAR, S_IDLE, S_START, S_MR_CHK, S_MR_A, S_MR_B, S_MR_C, S_MR_D, S_MR_E,
      S_BYTE, S_FINAL, S_SET_A, S_SET_B, S_SET_C, S_SET_D, S_SET_E, S_SET_F, S_SET_G,
      S_SET_H, S_FD_A, S_FD_LOOP, S_FD_K, S_FD_CMP, S_FD_CMP2, S_FD_U, S_FD_E, S_FD_TTL,
      S_FD_NEXT, S_FD_N2, S_DEL_D, S_RD, S_WR, S_EMIT
   } state_type;

   state_type    state_ff, state_in, ret_ff, ret_in;
   logic [1:0]   op_ff, op_in;
   logic [9:0]   klen_ff, klen_in;
   logic [15:0]  dlen_ff, dlen_in;
   logic [31:0]  ttl_ff, ttl_in;
   logic         ign_ff, ign_in;
   logic [16:0]  bc_ff, bc_in;
   logic [31:0]  hash_ff, hash_in;
   logic         fault_ff, fault_in;
   logic [PW-1:0] wp_ff, wp_in, old_ff, old_in, unu_ff, unu_in, clr_ff, clr_in;
   logic [7:0]   byte_ff, byte_in;
   logic         last_ff, last_in;
   logic [63:0]  now_ff, now_in;
   logic         fin_ff, fin_in;
   logic [16:0]  len_ff, len_in;
   logic [31:0]  p_ff, p_in, prev_ff, prev_in, tmp_ff, tmp_in, base_ff, base_in;
   logic [LW-1:0] loop_ff, loop_in;
   logic [9:0]   idx_ff, idx_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         n8_ff, n8_in, be_ff, be_in;
   logic [63:0]  acc_ff, acc_in, wval_ff, wval_in, diff_ff, diff_in;
   logic [2:0]   res_status_ff, res_status_in;
   logic [15:0]  res_offs_ff, res_offs_in, res_flen_ff, res_flen_in;
   logic [19:0]  res_tleft_ff, res_tleft_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [2:0]   rsp_status_ff, rsp_status_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   logic [7:0]   arena_mem [ARENA_BYTES];
   logic [7:0]   key_mem [KEY_DEPTH];
   logic [7:0]   mem_rdata_ff, key_rdata_ff;
   logic         mem_we, key_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]   mem_wdata;

   logic [31:0]  val32, kh, w32, acc_addr, cmp_addr, lim, byte_at;
   logic [3:0]   nbytes;
   logic         oob;
   logic [16:0]  expect_len;
   logic [33:0]  evict_nxt;
   logic [19:0]  ttl_cut;

   assign val32      = acc_ff[63:32];
   assign kh         = (hash_ff << 2) & HMASK;
   assign w32        = 32'(wp_ff);
   assign nbytes     = n8_ff ? 4'd8 : 4'd4;
   assign lim        = n8_ff ? (ARENA32 - 32'd8) : (ARENA32 - 32'd4);
   assign oob        = base_ff > lim;
   assign acc_addr   = base_ff + 32'(cnt_ff);
   assign cmp_addr   = p_ff + 32'(HDR_BYTES) + 32'(idx_ff);
   assign byte_at    = w32 + 32'(HDR_BYTES) + 32'(bc_ff);
   assign expect_len = 17'(klen_ff) + ((op_ff == OP_SET) ? 17'(dlen_ff) : 17'd0);
   assign evict_nxt  = 34'(old_ff) + 34'(tmp_ff) + 34'(val32) + 34'(HDR_BYTES);
   assign ttl_cut    = (ttl_ff > 32'(TTL_CAP)) ? TTL_CAP : ttl_ff[19:0];
   assign mem_raddr  = (state_ff == S_FD_CMP) ? cmp_addr[AW-1:0] : acc_addr[AW-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      state_in = state_ff;   ret_in = ret_ff;     op_in = op_ff;       klen_in = klen_ff;
      dlen_in = dlen_ff;     ttl_in = ttl_ff;     ign_in = ign_ff;     bc_in = bc_ff;
      hash_in = hash_ff;     fault_in = fault_ff; wp_in = wp_ff;       old_in = old_ff;
      unu_in = unu_ff;       clr_in = clr_ff;     byte_in = byte_ff;   last_in = last_ff;
      now_in = now_ff;       fin_in = fin_ff;     len_in = len_ff;     p_in = p_ff;
      prev_in = prev_ff;     tmp_in = tmp_ff;     base_in = base_ff;   loop_in = loop_ff;
      idx_in = idx_ff;       cnt_in = cnt_ff;     n8_in = n8_ff;       be_in = be_ff;
      acc_in = acc_ff;       wval_in = wval_ff;   diff_in = diff_ff;
      res_status_in = res_status_ff; res_offs_in = res_offs_ff;
      res_flen_in = res_flen_ff;     res_tleft_in = res_tleft_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff; rsp_data_in = rsp_data_ff;
      mem_we = 1'b0; mem_waddr = acc_addr[AW-1:0]; mem_wdata = wval_ff[7:0];
      key_we = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff[AW-1:0];
            mem_wdata = 8'd0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == PW'(ARENA_BYTES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               byte_in = req_tdata.byte_value;
               last_in = req_tlast;
               now_in  = TIME_OFS | 64'(req_tdata.now_seconds);
               if (bc_ff == 17'd0) begin
                  op_in   = req_tuser;
                  klen_in = req_tdata.key_len;
                  dlen_in = req_tdata.data_len;
                  ttl_in  = req_tdata.ttl_seconds;
                  ign_in  = (req_tuser == OP_NONE);
               end
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = S_BYTE;
            if (bc_ff == 17'd0 && op_ff == OP_SET && !fault_ff) begin
               if (klen_ff > 10'(MAX_KEY) || dlen_ff > 16'(MAX_DATA) || ttl_ff == 32'd0) begin
                  ign_in = 1'b1;
               end else begin
                  len_in   = 17'(klen_ff) + 17'(dlen_ff) + 17'(HDR_BYTES);
                  state_in = S_MR_CHK;
               end
            end
         end
         // evict from the oldest end until the new entry fits
         S_MR_CHK: begin
            if (33'(wp_ff) + 33'(len_ff) > 33'(old_ff)) begin
               n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0; ret_in = S_MR_A;
               if (old_ff == unu_ff) begin
                  if (wp_ff <= PW'(HEAD_BYTES)) begin
                     ign_in   = 1'b1;
                     state_in = S_BYTE;
                  end else begin
                     unu_in   = wp_ff;
                     old_in   = PW'(HEAD_BYTES);
                     wp_in    = PW'(HEAD_BYTES);
                     base_in  = HEAD32;
                     state_in = S_RD;
                  end
               end else begin
                  base_in  = 32'(old_ff);
                  state_in = S_RD;
               end
            end else begin
               state_in = S_BYTE;
            end
         end
         S_MR_A: begin
            p_in = val32; base_in = val32; n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0;
            ret_in = S_MR_B; state_in = S_RD;
         end
         S_MR_B: begin
            base_in = p_ff; wval_in = {32'd0, val32 ^ 32'(old_ff)};
            n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0; ret_in = S_MR_C; state_in = S_WR;
         end
         S_MR_C: begin
            base_in = 32'(old_ff) + 32'd4; n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0;
            ret_in = S_MR_D; state_in = S_RD;
         end
         S_MR_D: begin
            tmp_in = val32; base_in = 32'(old_ff) + 32'd8;
            n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0; ret_in = S_MR_E; state_in = S_RD;
         end
         S_MR_E: begin
            if (evict_nxt > 34'(unu_ff)) begin
               fault_in = 1'b1;
               state_in = S_BYTE;
            end else begin
               if (evict_nxt == 34'(unu_ff)) begin
                  unu_in = PW'(ARENA_BYTES);
                  old_in = PW'(ARENA_BYTES);
               end else begin
                  old_in = evict_nxt[PW-1:0];
               end
               state_in = S_MR_CHK;
            end
         end
         S_BYTE: begin
            if (bc_ff < expect_len && !fault_ff) begin
               if (bc_ff < 17'(klen_ff)) begin
                  key_we  = 1'b1;
                  hash_in = ((hash_ff << 5) + hash_ff) ^ 32'(byte_ff);
               end
               if (op_ff == OP_SET && !ign_ff) begin
                  if (byte_at < ARENA32) begin
                     mem_we    = 1'b1;
                     mem_waddr = byte_at[AW-1:0];
                     mem_wdata = byte_ff;
                  end else begin
                     fault_in = 1'b1;
                  end
               end
            end
            if (bc_ff != '1) bc_in = bc_ff + 1'b1;
            fin_in   = last_ff;
            state_in = last_ff ? S_FINAL : S_IDLE;
         end
         S_FINAL: begin
            res_offs_in = 16'd0; res_flen_in = 16'd0; res_tleft_in = 20'd0;
            n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0; base_in = kh;
            if (fault_ff) begin
               res_status_in = ST_FAULT; state_in = S_EMIT;
            end else if (bc_ff < expect_len || ign_ff) begin
               res_status_in = ST_IGN; state_in = S_EMIT;
            end else if (op_ff == OP_SET) begin
               ret_in = S_SET_A; state_in = S_RD;
            end else if (klen_ff > 10'(MAX_KEY)) begin
               res_status_in = ST_MISS; state_in = S_EMIT;
            end else begin
               prev_in = kh; loop_in = '0; ret_in = S_FD_A; state_in = S_RD;
            end
         end
         S_SET_A: begin
            p_in = val32; n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0;
            if (val32 != 32'd0) begin
               base_in = val32; ret_in = S_SET_B; state_in = S_RD;
            end else begin
               state_in = S_SET_C;
            end
         end
         S_SET_B: begin
            base_in = p_ff; wval_in = {32'd0, val32 ^ kh ^ w32};
            n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0; ret_in = S_SET_C; state_in = S_WR;
         end
         S_SET_C: begin
            base_in = w32; wval_in = {32'd0, p_ff ^ kh};
            n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0; ret_in = S_SET_D; state_in = S_WR;
         end
         S_SET_D: begin
            base_in = w32 + 32'd4; wval_in = 64'(klen_ff);
            n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0; ret_in = S_SET_E; state_in = S_WR;
         end
         S_SET_E: begin
            base_in = w32 + 32'd8; wval_in = 64'(dlen_ff);
            n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0; ret_in = S_SET_F; state_in = S_WR;
         end
         S_SET_F: begin
            base_in = w32 + 32'd12; wval_in = now_ff + 64'(ttl_cut);
            n8_in = 1'b1; be_in = 1'b1; cnt_in = 4'd0; ret_in = S_SET_G; state_in = S_WR;
         end
         S_SET_G: begin
            base_in = kh; wval_in = 64'(w32);
            n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0; ret_in = S_SET_H; state_in = S_WR;
         end
         S_SET_H: begin
            wp_in = PW'(33'(wp_ff) + 33'(len_ff));
            res_status_in = ST_DONE; state_in = S_EMIT;
         end
         S_FD_A: begin
            p_in = val32; state_in = S_FD_LOOP;
         end
         S_FD_LOOP: begin
            if (p_ff == 32'd0) begin
               res_status_in = ST_MISS; state_in = S_EMIT;
            end else begin
               base_in = p_ff + 32'd4; n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0;
               ret_in = S_FD_K; state_in = S_RD;
            end
         end
         S_FD_K: begin
            if (val32 == 32'(klen_ff)) begin
               if (34'(p_ff) + 34'(HDR_BYTES) + 34'(klen_ff) > 34'(ARENA32)) begin
                  fault_in = 1'b1; state_in = S_FINAL;
               end else begin
                  idx_in = 10'd0; state_in = S_FD_CMP;
               end
            end else begin
               state_in = S_FD_NEXT;
            end
         end
         S_FD_CMP: begin
            if (idx_ff == klen_ff) begin
               base_in = p_ff + 32'd8; n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0;
               ret_in = S_FD_U; state_in = S_RD;
            end else begin
               state_in = S_FD_CMP2;
            end
         end
         S_FD_CMP2: begin
            if (mem_rdata_ff == key_rdata_ff) begin
               idx_in = idx_ff + 1'b1; state_in = S_FD_CMP;
            end else begin
               state_in = S_FD_NEXT;
            end
         end
         S_FD_U: begin
            tmp_in = val32;
            if (35'(p_ff) + 35'(HDR_BYTES) + 35'(klen_ff) + 35'(val32) > 35'(ARENA32)) begin
               fault_in = 1'b1; state_in = S_FINAL;
            end else begin
               base_in = p_ff + 32'd12; n8_in = 1'b1; be_in = 1'b1; cnt_in = 4'd0;
               ret_in = S_FD_E; state_in = S_RD;
            end
         end
         S_FD_E: begin
            if (acc_ff < now_ff) begin
               res_status_in = ST_MISS; state_in = S_EMIT;
            end else if (op_ff == OP_GET) begin
               diff_in = acc_ff - now_ff; state_in = S_FD_TTL;
            end else begin
               base_in = p_ff + 32'd12; wval_in = now_ff - 64'(DEL_BACK);
               n8_in = 1'b1; be_in = 1'b1; cnt_in = 4'd0; ret_in = S_DEL_D; state_in = S_WR;
            end
         end
         S_FD_TTL: begin
            res_status_in = ST_FOUND;
            res_offs_in   = 16'(p_ff + 32'(HDR_BYTES) + 32'(klen_ff));
            res_flen_in   = tmp_ff[15:0];
            res_tleft_in  = (diff_ff > 64'(TTL_CAP)) ? TTL_CAP : diff_ff[19:0];
            state_in      = S_EMIT;
         end
         S_FD_NEXT: begin
            base_in = p_ff; n8_in = 1'b0; be_in = 1'b0; cnt_in = 4'd0;
            ret_in = S_FD_N2; state_in = S_RD;
         end
         S_FD_N2: begin
            p_in    = prev_ff ^ val32;
            prev_in = p_ff;
            loop_in = loop_ff + 1'b1;
            if (loop_ff >= LW'(CHAIN_LIMIT)) begin
               res_status_in = ST_MISS; state_in = S_EMIT;
            end else begin
               state_in = S_FD_LOOP;
            end
         end
         S_DEL_D: begin
            res_status_in = ST_DONE; state_in = S_EMIT;
         end
         // byte-serial read: address on one cycle, data folded in on the next
         S_RD: begin
            if (cnt_ff == 4'd0 && oob) begin
               fault_in = 1'b1;
               state_in = fin_ff ? S_FINAL : S_BYTE;
            end else begin
               if (cnt_ff != 4'd0) begin
                  acc_in = be_ff ? {acc_ff[55:0], mem_rdata_ff} : {mem_rdata_ff, acc_ff[63:8]};
               end
               if (cnt_ff == nbytes) state_in = ret_ff;
               else cnt_in = cnt_ff + 1'b1;
            end
         end
         S_WR: begin
            if (cnt_ff == 4'd0 && oob) begin
               fault_in = 1'b1;
               state_in = fin_ff ? S_FINAL : S_BYTE;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = be_ff ? wval_ff[63:56] : wval_ff[7:0];
               wval_in   = be_ff ? (wval_ff << 8) : (wval_ff >> 8);
               if (cnt_ff == nbytes - 4'd1) state_in = ret_ff;
               else cnt_in = cnt_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = '{pad: 4'd0, ttl_left: res_tleft_ff,
                                 found_len: res_flen_ff, data_offset: res_offs_ff};
               bc_in    = 17'd0;
               hash_in  = HASH_SEED;
               fin_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         bc_ff        <= 17'd0;
         hash_ff      <= HASH_SEED;
         fault_ff     <= 1'b0;
         wp_ff        <= PW'(HEAD_BYTES);
         old_ff       <= PW'(ARENA_BYTES);
         unu_ff       <= PW'(ARENA_BYTES);
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         bc_ff        <= bc_in;
         hash_ff      <= hash_in;
         fault_ff     <= fault_in;
         wp_ff        <= wp_in;
         old_ff       <= old_in;
         unu_ff       <= unu_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff <= ret_in;   op_ff <= op_in;       klen_ff <= klen_in;   dlen_ff <= dlen_in;
      ttl_ff <= ttl_in;   ign_ff <= ign_in;     byte_ff <= byte_in;   last_ff <= last_in;
      now_ff <= now_in;   len_ff <= len_in;     p_ff <= p_in;         prev_ff <= prev_in;
      tmp_ff <= tmp_in;   base_ff <= base_in;   loop_ff <= loop_in;   idx_ff <= idx_in;
      cnt_ff <= cnt_in;   n8_ff <= n8_in;       be_ff <= be_in;       acc_ff <= acc_in;
      wval_ff <= wval_in; diff_ff <= diff_in;
      res_status_ff <= res_status_in; res_offs_ff <= res_offs_in;
      res_flen_ff   <= res_flen_in;   res_tleft_ff <= res_tleft_in;
      rsp_status_ff <= rsp_status_in; rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) arena_mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= arena_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[bc_ff[9:0]] <= byte_ff;
      key_rdata_ff <= key_mem[idx_ff];
   end

endmodule

// ----- design/ekvrc_check.sv -----
// Port-level checks for the expiring key-value ring cache, bound to the top level.
`timescale 1ns / 1ps
module ekvrc_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import ekvrc_pkg::*;

   logic seen_fault_ff;

   // remember that a fault beat went out
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_fault_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tuser == ST_FAULT) begin
         seen_fault_ff <= 1'b1;
      end
   end

   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && seen_fault_ff |-> rsp_tuser == ST_FAULT)
      else $error("result after a fault is not a fault");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_FOUND |-> rsp_tdata == 56'd0)
      else $error("non-hit result carries nonzero fields");

   a_ttl_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FOUND |-> rsp_tdata[51:32] <= TTL_CAP)
      else $error("ttl_left above cap");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

endmodule

bind expiring_kv_ring_cache ekvrc_check u_ekvrc_check (.*);
